FILE: src/hlpd_pkg.sv
`default_nettype none

package hlpd_pkg;

    typedef enum logic [1:0] {
        ACT_POWER  = 2'd0,
        ACT_HUE    = 2'd1,
        ACT_SAT    = 2'd2,
        ACT_BRIGHT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        STEP_SF,
        STEP_SFC,
        STEP_P,
        STEP_Q,
        STEP_T
    } step_t;

    typedef struct packed {
        logic        light_on;
        logic [16:0] v;
        logic [16:0] s;
        logic [15:0] f;
        sector_t     sector;
    } hlpd_job_t;

    localparam logic [16:0] ONE_Q16    = 17'h10000;
    localparam logic [11:0] HUE_MAX    = 12'd3600;
    localparam logic [11:0] SAT_MAX    = 12'd1000;
    localparam logic [11:0] BRIGHT_MAX = 12'd100;
    localparam logic [11:0] SPAN_1     = 12'd600;
    localparam logic [11:0] SPAN_2     = 12'd1200;
    localparam logic [11:0] SPAN_3     = 12'd1800;
    localparam logic [11:0] SPAN_4     = 12'd2400;
    localparam logic [11:0] SPAN_5     = 12'd3000;

    // reciprocals: v = b*2^32/100 >> 16, s = sat*2^33/1000 >> 17, f = r*2^33/600 >> 17
    localparam logic [25:0] V_RECIP = 26'd42949673;
    localparam logic [23:0] S_RECIP = 24'd8589935;
    localparam logic [23:0] F_RECIP = 24'd14316558;

    localparam logic [16:0] V_RESET = 17'd655;

endpackage

`default_nettype wire

FILE: src/hsv_led_pwm_duty.sv
`default_nettype none

// HSV lamp setting to three PWM duties. Each input transfer sets the on flag or
// one colour setting (hue in tenths of a degree, saturation in tenths of a percent,
// brightness in percent; larger values saturate, setting a colour turns the lamp
// on), and each produces exactly one output transfer of red, green and blue
// duties of DUTY_BITS bits, full scale 2^DUTY_BITS-1. The front updates the
// settings in the cycle of the transfer and queues a snapshot; the back runs the
// five Q16 products of the six-sector formula through one shared 17x17 multiplier,
// one per cycle, and takes the next item from the queue only after the last result
// has been loaded into the output register. Up to two further items are
// taken into the queue while one is in work, and a finished result waits in the
// output register without blocking input.
module hsv_led_pwm_duty #(
    parameter int DUTY_BITS = 13
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           action,
    input  wire logic [11:0]          setting_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DUTY_BITS-1:0]      duty_red,
    output logic [DUTY_BITS-1:0]      duty_green,
    output logic [DUTY_BITS-1:0]      duty_blue
);

    logic                q_full;
    logic                q_empty;
    logic                push;
    logic                pop;
    hlpd_pkg::hlpd_job_t push_job;
    hlpd_pkg::hlpd_job_t pop_job;

    hlpd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .setting_value (setting_value),
        .q_full        (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    hlpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    hlpd_back #(
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (q_empty),
        .pop_job    (pop_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .duty_red   (duty_red),
        .duty_green (duty_green),
        .duty_blue  (duty_blue)
    );

endmodule

`default_nettype wire

FILE: src/hlpd_front.sv
`default_nettype none

module hlpd_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         action,
    input  wire logic [11:0]        setting_value,
    input  wire logic               q_full,
    output logic                    push,
    output hlpd_pkg::hlpd_job_t     push_job
);

    logic              on_reg, on_next;
    logic [16:0]       v_reg, v_next;
    logic [16:0]       s_reg, s_next;
    logic [15:0]       f_reg, f_next;
    hlpd_pkg::sector_t sector_reg, sector_next;

    logic [11:0] hue_clamp;
    logic [11:0] hue_wrap;
    logic [11:0] hue_base;
    logic [11:0] hue_rem;
    logic [11:0] sat_clamp;
    logic [11:0] bright_clamp;
    logic [32:0] v_prod;
    logic [33:0] s_prod;
    logic [33:0] f_prod;
    hlpd_pkg::sector_t hue_sector;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    assign hue_clamp    = (setting_value > hlpd_pkg::HUE_MAX) ? hlpd_pkg::HUE_MAX
                                                              : setting_value;
    assign hue_wrap     = (hue_clamp == hlpd_pkg::HUE_MAX) ? 12'd0 : hue_clamp;
    assign sat_clamp    = (setting_value > hlpd_pkg::SAT_MAX) ? hlpd_pkg::SAT_MAX
                                                              : setting_value;
    assign bright_clamp = (setting_value > hlpd_pkg::BRIGHT_MAX) ? hlpd_pkg::BRIGHT_MAX
                                                                 : setting_value;

    always_comb
    begin
        if (hue_wrap >= hlpd_pkg::SPAN_5)
        begin
            hue_sector = hlpd_pkg::SEC_MAG_RED;
            hue_base   = hlpd_pkg::SPAN_5;
        end
        else if (hue_wrap >= hlpd_pkg::SPAN_4)
        begin
            hue_sector = hlpd_pkg::SEC_BLU_MAG;
            hue_base   = hlpd_pkg::SPAN_4;
        end
        else if (hue_wrap >= hlpd_pkg::SPAN_3)
        begin
            hue_sector = hlpd_pkg::SEC_CYN_BLU;
            hue_base   = hlpd_pkg::SPAN_3;
        end
        else if (hue_wrap >= hlpd_pkg::SPAN_2)
        begin
            hue_sector = hlpd_pkg::SEC_GRN_CYN;
            hue_base   = hlpd_pkg::SPAN_2;
        end
        else if (hue_wrap >= hlpd_pkg::SPAN_1)
        begin
            hue_sector = hlpd_pkg::SEC_YEL_GRN;
            hue_base   = hlpd_pkg::SPAN_1;
        end
        else
        begin
            hue_sector = hlpd_pkg::SEC_RED_YEL;
            hue_base   = 12'd0;
        end
    end

    assign hue_rem = hue_wrap - hue_base;
    assign v_prod  = {26'd0, bright_clamp[6:0]} * {7'd0, hlpd_pkg::V_RECIP};
    assign s_prod  = {24'd0, sat_clamp[9:0]} * {10'd0, hlpd_pkg::S_RECIP};
    assign f_prod  = {24'd0, hue_rem[9:0]} * {10'd0, hlpd_pkg::F_RECIP};

    always_comb
    begin
        on_next     = on_reg;
        v_next      = v_reg;
        s_next      = s_reg;
        f_next      = f_reg;
        sector_next = sector_reg;
        unique case (hlpd_pkg::action_t'(action))
            hlpd_pkg::ACT_POWER:
            begin
                on_next = (setting_value != 12'd0);
            end
            hlpd_pkg::ACT_HUE:
            begin
                on_next     = 1'b1;
                f_next      = f_prod[32:17];
                sector_next = hue_sector;
            end
            hlpd_pkg::ACT_SAT:
            begin
                on_next = 1'b1;
                s_next  = s_prod[33:17];
            end
            hlpd_pkg::ACT_BRIGHT:
            begin
                on_next = 1'b1;
                v_next  = v_prod[32:16];
            end
        endcase
    end

    assign push_job.light_on = on_next;
    assign push_job.v        = v_next;
    assign push_job.s        = s_next;
    assign push_job.f        = f_next;
    assign push_job.sector   = sector_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg     <= 1'b1;
            v_reg      <= hlpd_pkg::V_RESET;
            s_reg      <= 17'd0;
            f_reg      <= 16'd0;
            sector_reg <= hlpd_pkg::SEC_RED_YEL;
        end
        else if (push)
        begin
            on_reg     <= on_next;
            v_reg      <= v_next;
            s_reg      <= s_next;
            f_reg      <= f_next;
            sector_reg <= sector_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/hlpd_queue.sv
`default_nettype none

module hlpd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire hlpd_pkg::hlpd_job_t  push_job,
    output logic                      full,
    input  wire logic                 pop,
    output hlpd_pkg::hlpd_job_t       pop_job,
    output logic                      empty
);

    hlpd_pkg::hlpd_job_t entry_reg [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

FILE: src/hlpd_back.sv
`default_nettype none

module hlpd_back #(
    parameter int DUTY_BITS = 13
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 empty,
    input  wire hlpd_pkg::hlpd_job_t  pop_job,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DUTY_BITS-1:0]      duty_red,
    output logic [DUTY_BITS-1:0]      duty_green,
    output logic [DUTY_BITS-1:0]      duty_blue
);

    hlpd_pkg::back_state_t state_reg, state_next;
    hlpd_pkg::step_t       step_reg, step_next;
    hlpd_pkg::hlpd_job_t   job_reg, job_next;

    logic [16:0] sf_reg, sf_next;
    logic [16:0] sfc_reg, sfc_next;
    logic [16:0] p_reg, p_next;
    logic [16:0] q_reg, q_next;
    logic [16:0] t_reg, t_next;

    logic                 out_valid_reg, out_valid_next;
    logic [DUTY_BITS-1:0] duty_red_reg, duty_red_next;
    logic [DUTY_BITS-1:0] duty_green_reg, duty_green_next;
    logic [DUTY_BITS-1:0] duty_blue_reg, duty_blue_next;

    logic [16:0] mul_a;
    logic [16:0] mul_b;
    logic [33:0] prod;
    logic [16:0] prod_q16;
    logic [16:0] comp_r;
    logic [16:0] comp_g;
    logic [16:0] comp_b;
    logic        load;

    function automatic logic [DUTY_BITS-1:0] to_duty(input logic [16:0] c);
        logic [16+DUTY_BITS:0] w;
        w = {c, {DUTY_BITS{1'b0}}} - {{DUTY_BITS{1'b0}}, c};
        return w[15+DUTY_BITS:16];
    endfunction

    always_comb
    begin
        unique case (step_reg)
            hlpd_pkg::STEP_SF:
            begin
                mul_a = job_reg.s;
                mul_b = {1'b0, job_reg.f};
            end
            hlpd_pkg::STEP_SFC:
            begin
                mul_a = job_reg.s;
                mul_b = hlpd_pkg::ONE_Q16 - {1'b0, job_reg.f};
            end
            hlpd_pkg::STEP_P:
            begin
                mul_a = job_reg.v;
                mul_b = hlpd_pkg::ONE_Q16 - job_reg.s;
            end
            hlpd_pkg::STEP_Q:
            begin
                mul_a = job_reg.v;
                mul_b = hlpd_pkg::ONE_Q16 - sf_reg;
            end
            hlpd_pkg::STEP_T:
            begin
                mul_a = job_reg.v;
                mul_b = hlpd_pkg::ONE_Q16 - sfc_reg;
            end
            default:
            begin
                mul_a = 17'd0;
                mul_b = 17'd0;
            end
        endcase
    end

    assign prod     = {17'd0, mul_a} * {17'd0, mul_b};
    assign prod_q16 = prod[32:16];

    always_comb
    begin
        if (!job_reg.light_on)
        begin
            comp_r = 17'd0;
            comp_g = 17'd0;
            comp_b = 17'd0;
        end
        else
        begin
            case (job_reg.sector)
                hlpd_pkg::SEC_RED_YEL:
                begin
                    comp_r = job_reg.v;
                    comp_g = t_reg;
                    comp_b = p_reg;
                end
                hlpd_pkg::SEC_YEL_GRN:
                begin
                    comp_r = q_reg;
                    comp_g = job_reg.v;
                    comp_b = p_reg;
                end
                hlpd_pkg::SEC_GRN_CYN:
                begin
                    comp_r = p_reg;
                    comp_g = job_reg.v;
                    comp_b = t_reg;
                end
                hlpd_pkg::SEC_CYN_BLU:
                begin
                    comp_r = p_reg;
                    comp_g = q_reg;
                    comp_b = job_reg.v;
                end
                hlpd_pkg::SEC_BLU_MAG:
                begin
                    comp_r = t_reg;
                    comp_g = p_reg;
                    comp_b = job_reg.v;
                end
                default:
                begin
                    comp_r = job_reg.v;
                    comp_g = p_reg;
                    comp_b = q_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        job_next        = job_reg;
        sf_next         = sf_reg;
        sfc_next        = sfc_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        t_next          = t_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        duty_red_next   = duty_red_reg;
        duty_green_next = duty_green_reg;
        duty_blue_next  = duty_blue_reg;
        pop             = 1'b0;
        load            = 1'b0;
        unique case (state_reg)
            hlpd_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_next   = pop_job;
                    step_next  = hlpd_pkg::STEP_SF;
                    state_next = hlpd_pkg::BK_MUL;
                end
            end
            hlpd_pkg::BK_MUL:
            begin
                unique case (step_reg)
                    hlpd_pkg::STEP_SF:
                    begin
                        sf_next   = prod_q16;
                        step_next = hlpd_pkg::STEP_SFC;
                    end
                    hlpd_pkg::STEP_SFC:
                    begin
                        sfc_next  = prod_q16;
                        step_next = hlpd_pkg::STEP_P;
                    end
                    hlpd_pkg::STEP_P:
                    begin
                        p_next    = prod_q16;
                        step_next = hlpd_pkg::STEP_Q;
                    end
                    hlpd_pkg::STEP_Q:
                    begin
                        q_next    = prod_q16;
                        step_next = hlpd_pkg::STEP_T;
                    end
                    hlpd_pkg::STEP_T:
                    begin
                        t_next     = prod_q16;
                        state_next = hlpd_pkg::BK_OUT;
                    end
                    default:
                    begin
                        state_next = hlpd_pkg::BK_IDLE;
                    end
                endcase
            end
            hlpd_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load            = 1'b1;
                    out_valid_next  = 1'b1;
                    duty_red_next   = to_duty(comp_r);
                    duty_green_next = to_duty(comp_g);
                    duty_blue_next  = to_duty(comp_b);
                    state_next      = hlpd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = hlpd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hlpd_pkg::BK_IDLE;
            step_reg      <= hlpd_pkg::STEP_SF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        sf_reg         <= sf_next;
        sfc_reg        <= sfc_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        t_reg          <= t_next;
        duty_red_reg   <= duty_red_next;
        duty_green_reg <= duty_green_next;
        duty_blue_reg  <= duty_blue_next;
    end

    assign out_valid  = out_valid_reg;
    assign duty_red   = duty_red_reg;
    assign duty_green = duty_green_reg;
    assign duty_blue  = duty_blue_reg;

`ifndef SYNTHESIS
    a_last_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hlpd_pkg::BK_MUL && step_reg == hlpd_pkg::STEP_T)
        |=> state_reg == hlpd_pkg::BK_OUT)
        else $error("sequencer skipped result stage");

    a_off_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !job_reg.light_on)
        |=> duty_red == '0 && duty_green == '0 && duty_blue == '0)
        else $error("nonzero duty with light off");

    a_gray_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hlpd_pkg::BK_OUT && job_reg.s == 17'd0)
        |-> p_reg == job_reg.v && q_reg == job_reg.v && t_reg == job_reg.v)
        else $error("zero saturation gives unequal components");
`endif

endmodule

`default_nettype wire

FILE: tb/hsv_led_pwm_duty_tb.sv
`timescale 1ns / 1ps

module hsv_led_pwm_duty_tb;

    localparam int DUTY_W = 13;
    localparam longint unsigned DMAX = (64'd1 << DUTY_W) - 1;
    localparam longint unsigned Q16_ONE = 64'd65536;
    localparam int RANDOM_ITEMS = 950;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
    } duty_set_t;

    class duty_scoreboard;
        logic [11:0] hue;
        logic [9:0] sat;
        logic [6:0] bright;
        logic lamp_on;
        duty_set_t expected_q[$];
        int errors;

        function new();
            hue = 12'd0;
            sat = 10'd0;
            bright = 7'd1;
            lamp_on = 1'b1;
            errors = 0;
        endfunction

        function logic [DUTY_W-1:0] scale(longint unsigned comp);
            return DUTY_W'(((comp * DMAX) >> 16) & DMAX);
        endfunction

        function void note_setting(hlpd_pkg::action_t act, logic [11:0] val);
            longint unsigned v, s, h, f, p, q, t, r, g, b;
            hlpd_pkg::sector_t sec;
            duty_set_t d;
            case (act)
                hlpd_pkg::ACT_POWER: lamp_on = (val != 12'd0);
                hlpd_pkg::ACT_HUE:
                begin
                    hue = (val > hlpd_pkg::HUE_MAX) ? hlpd_pkg::HUE_MAX : val;
                    lamp_on = 1'b1;
                end
                hlpd_pkg::ACT_SAT:
                begin
                    sat = 10'((val > hlpd_pkg::SAT_MAX) ? hlpd_pkg::SAT_MAX : val);
                    lamp_on = 1'b1;
                end
                default:
                begin
                    bright = 7'((val > hlpd_pkg::BRIGHT_MAX) ? hlpd_pkg::BRIGHT_MAX : val);
                    lamp_on = 1'b1;
                end
            endcase
            r = 0;
            g = 0;
            b = 0;
            if (lamp_on) begin
                v = (longint'(bright) * Q16_ONE) / 100;
                s = (longint'(sat) * Q16_ONE) / 1000;
                if (s == 0) begin
                    r = v;
                    g = v;
                    b = v;
                end else begin
                    h = (hue >= hlpd_pkg::HUE_MAX) ? 0 : longint'(hue);
                    sec = hlpd_pkg::sector_t'(h / 600);
                    f = ((h % 600) * Q16_ONE) / 600;
                    p = (v * (Q16_ONE - s)) >> 16;
                    q = (v * (Q16_ONE - ((s * f) >> 16))) >> 16;
                    t = (v * (Q16_ONE - ((s * (Q16_ONE - f)) >> 16))) >> 16;
                    case (sec)
                        hlpd_pkg::SEC_RED_YEL: begin r = v; g = t; b = p; end
                        hlpd_pkg::SEC_YEL_GRN: begin r = q; g = v; b = p; end
                        hlpd_pkg::SEC_GRN_CYN: begin r = p; g = v; b = t; end
                        hlpd_pkg::SEC_CYN_BLU: begin r = p; g = q; b = v; end
                        hlpd_pkg::SEC_BLU_MAG: begin r = t; g = p; b = v; end
                        default:               begin r = v; g = p; b = q; end
                    endcase
                end
            end
            d.red = scale(r);
            d.green = scale(g);
            d.blue = scale(b);
            expected_q.push_back(d);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [DUTY_W-1:0] r, logic [DUTY_W-1:0] g,
                          logic [DUTY_W-1:0] b);
            duty_set_t d;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result r=%0d g=%0d b=%0d", r, g, b));
            end else begin
                d = expected_q.pop_front();
                if (r !== d.red)
                    report($sformatf("duty_red got %0d want %0d", r, d.red));
                if (g !== d.green)
                    report($sformatf("duty_green got %0d want %0d", g, d.green));
                if (b !== d.blue)
                    report($sformatf("duty_blue got %0d want %0d", b, d.blue));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    hlpd_pkg::action_t action;
    logic [11:0] setting_value;
    logic out_valid;
    logic out_ready;
    logic [DUTY_W-1:0] duty_red;
    logic [DUTY_W-1:0] duty_green;
    logic [DUTY_W-1:0] duty_blue;
    logic calm;

    duty_scoreboard sb = new();

    hsv_led_pwm_duty #(
        .DUTY_BITS(DUTY_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .setting_value(setting_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .duty_red(duty_red),
        .duty_green(duty_green),
        .duty_blue(duty_blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task send_setting(hlpd_pkg::action_t act, logic [11:0] val);
        while (!calm && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        setting_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_setting(act, val);
        @(negedge clk);
    endtask

    task send_random();
        hlpd_pkg::action_t act;
        logic [11:0] val;
        logic [11:0] top;
        act = hlpd_pkg::action_t'($urandom_range(3));
        if (act == hlpd_pkg::ACT_POWER) begin
            if ($urandom_range(1) == 0)
                val = 12'd0;
            else if ($urandom_range(3) == 0)
                val = 12'($urandom_range(4095));
            else
                val = 12'd1;
        end else begin
            top = (act == hlpd_pkg::ACT_HUE) ? hlpd_pkg::HUE_MAX
                : (act == hlpd_pkg::ACT_SAT) ? hlpd_pkg::SAT_MAX : hlpd_pkg::BRIGHT_MAX;
            case ($urandom_range(9))
                0: val = 12'($urandom_range(4095));
                1: val = top;
                2: val = 12'd0;
                default: val = 12'($urandom_range(top));
            endcase
        end
        send_setting(act, val);
    endtask

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 17);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(duty_red, duty_green, duty_blue);

    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = hlpd_pkg::ACT_POWER;
        setting_value = 12'd0;
        out_ready = 1'b0;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_setting(hlpd_pkg::ACT_BRIGHT, 12'd100);
        send_setting(hlpd_pkg::ACT_SAT, 12'd1000);
        send_setting(hlpd_pkg::ACT_HUE, 12'd0);
        send_setting(hlpd_pkg::ACT_HUE, 12'd900);
        send_setting(hlpd_pkg::ACT_HUE, 12'd1500);
        send_setting(hlpd_pkg::ACT_HUE, 12'd2100);
        send_setting(hlpd_pkg::ACT_HUE, 12'd2700);
        send_setting(hlpd_pkg::ACT_HUE, 12'd3300);
        send_setting(hlpd_pkg::ACT_HUE, 12'd3600);
        send_setting(hlpd_pkg::ACT_HUE, 12'd4095);
        send_setting(hlpd_pkg::ACT_HUE, 12'd599);
        send_setting(hlpd_pkg::ACT_POWER, 12'd0);
        send_setting(hlpd_pkg::ACT_POWER, 12'd0);
        send_setting(hlpd_pkg::ACT_POWER, 12'd4095);
        send_setting(hlpd_pkg::ACT_SAT, 12'd0);
        send_setting(hlpd_pkg::ACT_SAT, 12'd4095);
        send_setting(hlpd_pkg::ACT_BRIGHT, 12'd0);
        send_setting(hlpd_pkg::ACT_BRIGHT, 12'd4095);
        send_setting(hlpd_pkg::ACT_POWER, 12'd0);
        send_setting(hlpd_pkg::ACT_HUE, 12'd1800);
        send_setting(hlpd_pkg::ACT_SAT, 12'd500);
        send_setting(hlpd_pkg::ACT_POWER, 12'd1);
        send_setting(hlpd_pkg::ACT_BRIGHT, 12'd127);
        send_setting(hlpd_pkg::ACT_SAT, 12'd1);
        send_setting(hlpd_pkg::ACT_HUE, 12'd3599);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 300 && i < 550);
            send_random();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
